>>> sv/gds_pkg.sv
// ----------------------------------------------------------------------------
// gds_pkg
// Types, constants and helpers shared by the Gregorian date stepper.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int unsigned DAY_W   = 5;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned QUOT_W  = 12;

    localparam logic [YEAR_W-1:0]  C_MIN_YEAR = YEAR_W'(1);
    localparam logic [YEAR_W-1:0]  C_MAX_YEAR = YEAR_W'(9999);
    localparam logic [MONTH_W-1:0] C_JAN      = MONTH_W'(1);
    localparam logic [MONTH_W-1:0] C_FEB      = MONTH_W'(2);
    localparam logic [MONTH_W-1:0] C_APR      = MONTH_W'(4);
    localparam logic [MONTH_W-1:0] C_JUN      = MONTH_W'(6);
    localparam logic [MONTH_W-1:0] C_SEP      = MONTH_W'(9);
    localparam logic [MONTH_W-1:0] C_NOV      = MONTH_W'(11);
    localparam logic [MONTH_W-1:0] C_DEC      = MONTH_W'(12);
    localparam logic [DAY_W-1:0]   C_FIRST_DAY = DAY_W'(1);
    localparam logic [DAY_W-1:0]   C_DAYS_LONG = DAY_W'(31);
    localparam logic [DAY_W-1:0]   C_DAYS_SHORT = DAY_W'(30);
    localparam logic [DAY_W-1:0]   C_DAYS_FEB  = DAY_W'(28);
    localparam logic [DAY_W-1:0]   C_DAYS_FEB_LEAP = DAY_W'(29);

    // multiplicative inverse of 25 modulo 2**12 and the divisibility bound
    localparam logic [QUOT_W-1:0] C_INV25       = QUOT_W'(3113);
    localparam logic [QUOT_W-1:0] C_DIV25_LIMIT = QUOT_W'((2**QUOT_W - 1) / 25);

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_date;

    typedef struct packed {
        t_date              date;
        logic               range_ok;
        logic               year_div4;
        logic               year_div16;
        logic [QUOT_W-1:0]  prod100;
        logic [QUOT_W-1:0]  prod400;
    } t_stage1;

    typedef struct packed {
        t_date              date;
        logic               date_ok;
        logic [DAY_W-1:0]   month_length;
        logic [DAY_W-1:0]   prev_length;
    } t_stage2;

    typedef struct packed {
        logic               date_ok;
        logic [DAY_W-1:0]   month_length;
        logic               prev_ok;
        t_date              prev;
        logic               next_ok;
        t_date              next;
    } t_result;

    function automatic logic [DAY_W-1:0] f_month_length(
        input logic [MONTH_W-1:0] month,
        input logic               leap
    );
        logic [DAY_W-1:0] len;
        case (month) inside
            C_FEB:                      len = leap ? C_DAYS_FEB_LEAP : C_DAYS_FEB;
            C_APR, C_JUN, C_SEP, C_NOV: len = C_DAYS_SHORT;
            default:                    len = C_DAYS_LONG;
        endcase
        return len;
    endfunction

endpackage

>>> sv/gds_in_if.sv
// ----------------------------------------------------------------------------
// gds_in_if
// Input channel: one date per transfer.
// ----------------------------------------------------------------------------
interface gds_in_if
    import gds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   in_day;
    logic [MONTH_W-1:0] in_month;
    logic [YEAR_W-1:0]  in_year;

    modport source (output valid, in_day, in_month, in_year, input ready);
    modport sink   (input valid, in_day, in_month, in_year, output ready);
endinterface

>>> sv/gds_out_if.sv
// ----------------------------------------------------------------------------
// gds_out_if
// Output channel: check result, month length, previous and next date.
// ----------------------------------------------------------------------------
interface gds_out_if
    import gds_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               date_ok;
    logic [DAY_W-1:0]   month_length;
    logic               prev_ok;
    logic [DAY_W-1:0]   prev_day;
    logic [MONTH_W-1:0] prev_month;
    logic [YEAR_W-1:0]  prev_year;
    logic               next_ok;
    logic [DAY_W-1:0]   next_day;
    logic [MONTH_W-1:0] next_month;
    logic [YEAR_W-1:0]  next_year;

    modport source (
        output valid, date_ok, month_length, prev_ok, prev_day, prev_month,
               prev_year, next_ok, next_day, next_month, next_year,
        input  ready
    );
    modport sink (
        input  valid, date_ok, month_length, prev_ok, prev_day, prev_month,
               prev_year, next_ok, next_day, next_month, next_year,
        output ready
    );
endinterface

>>> sv/gds_stage_div.sv
// ----------------------------------------------------------------------------
// gds_stage_div
// Stage 1: range checks and divisibility products for the leap rule.
// ----------------------------------------------------------------------------
module gds_stage_div
    import gds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_date   i_date,
    output logic    o_valid,
    input  logic    i_ready,
    output t_stage1 o_data
);

    logic    r_valid;
    t_stage1 r_data;
    t_stage1 n_data;

    logic [QUOT_W-1:0]   w_q100;
    logic [QUOT_W-1:0]   w_q400;
    logic [2*QUOT_W-1:0] w_p100;
    logic [2*QUOT_W-1:0] w_p400;

    assign o_ready = !r_valid || i_ready;

    // y/4 and y/16 are tested for divisibility by 25 through the inverse
    assign w_q100 = i_date.year[YEAR_W-1:2];
    assign w_q400 = QUOT_W'(i_date.year[YEAR_W-1:4]);
    assign w_p100 = (2*QUOT_W)'(w_q100) * (2*QUOT_W)'(C_INV25);
    assign w_p400 = (2*QUOT_W)'(w_q400) * (2*QUOT_W)'(C_INV25);

    always_comb begin
        n_data.date       = i_date;
        n_data.range_ok   = (i_date.year >= C_MIN_YEAR) && (i_date.year <= C_MAX_YEAR)
                         && (i_date.month >= C_JAN) && (i_date.month <= C_DEC)
                         && (i_date.day != '0);
        n_data.year_div4  = (i_date.year[1:0] == 2'b00);
        n_data.year_div16 = (i_date.year[3:0] == 4'b0000);
        n_data.prod100    = w_p100[QUOT_W-1:0];
        n_data.prod400    = w_p400[QUOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/gds_stage_len.sv
// ----------------------------------------------------------------------------
// gds_stage_len
// Stage 2: leap decision, month lengths and date validity.
// ----------------------------------------------------------------------------
module gds_stage_len
    import gds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_stage1 i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_stage2 o_data
);

    logic    r_valid;
    t_stage2 r_data;
    t_stage2 n_data;

    logic w_div100;
    logic w_div400;
    logic w_leap;

    assign o_ready = !r_valid || i_ready;

    assign w_div100 = i_data.year_div4  && (i_data.prod100 <= C_DIV25_LIMIT);
    assign w_div400 = i_data.year_div16 && (i_data.prod400 <= C_DIV25_LIMIT);
    assign w_leap   = w_div400 || (i_data.year_div4 && !w_div100);

    always_comb begin
        n_data.date         = i_data.date;
        n_data.month_length = f_month_length(i_data.date.month, w_leap);
        // only used when the month is above january
        n_data.prev_length  = f_month_length(i_data.date.month - C_JAN, w_leap);
        n_data.date_ok      = i_data.range_ok && (i_data.date.day <= n_data.month_length);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/gds_stage_step.sv
// ----------------------------------------------------------------------------
// gds_stage_step
// Stage 3: previous and next date, result register.
// ----------------------------------------------------------------------------
module gds_stage_step
    import gds_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_stage2 i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_data
);

    logic    r_valid;
    t_result r_data;
    t_result n_data;
    t_date   w_d;

    assign o_ready = !r_valid || i_ready;
    assign w_d     = i_data.date;

    always_comb begin
        n_data = '0;
        if (i_data.date_ok) begin
            n_data.date_ok      = 1'b1;
            n_data.month_length = i_data.month_length;

            n_data.prev_ok = 1'b1;
            n_data.prev    = w_d;
            if (w_d.day > C_FIRST_DAY) begin
                n_data.prev.day = w_d.day - C_FIRST_DAY;
            end else if (w_d.month > C_JAN) begin
                n_data.prev.month = w_d.month - C_JAN;
                n_data.prev.day   = i_data.prev_length;
            end else if (w_d.year > C_MIN_YEAR) begin
                n_data.prev.year  = w_d.year - C_MIN_YEAR;
                n_data.prev.month = C_DEC;
                n_data.prev.day   = C_DAYS_LONG;
            end else begin
                n_data.prev_ok = 1'b0;
                n_data.prev    = '0;
            end

            n_data.next_ok = 1'b1;
            n_data.next    = w_d;
            if (w_d.day < i_data.month_length) begin
                n_data.next.day = w_d.day + C_FIRST_DAY;
            end else if (w_d.month < C_DEC) begin
                n_data.next.day   = C_FIRST_DAY;
                n_data.next.month = w_d.month + C_JAN;
            end else begin
                // year rollover, past the last year the flag drops
                n_data.next.day   = C_FIRST_DAY;
                n_data.next.month = C_JAN;
                n_data.next.year  = w_d.year + C_MIN_YEAR;
                n_data.next_ok    = (w_d.year != C_MAX_YEAR);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> sv/gregorian_date_step.sv
// ----------------------------------------------------------------------------
// gregorian_date_step
// Gregorian date checker with previous and next date.
// ----------------------------------------------------------------------------
// Accepts one date per clock cycle while the output does not stall, and returns
// its result through three register stages: the divisibility products of
// the leap rule, the month lengths and validity, then the previous and next
// date in the output register. The ready of each stage follows the stage
// after it, so a stall on the output holds every full stage in place while
// an empty stage still takes the item in front of it. An invalid date gives
// a result with every field zero.
// ----------------------------------------------------------------------------
module gregorian_date_step
    import gds_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    gds_in_if.sink    i_in,
    gds_out_if.source o_out
);

    t_date   w_date;
    logic    w_v1;
    logic    w_r1;
    t_stage1 w_d1;
    logic    w_v2;
    logic    w_r2;
    t_stage2 w_d2;
    t_result w_res;

    assign w_date.day   = i_in.in_day;
    assign w_date.month = i_in.in_month;
    assign w_date.year  = i_in.in_year;

    gds_stage_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in.valid),
        .o_ready (i_in.ready),
        .i_date  (w_date),
        .o_valid (w_v1),
        .i_ready (w_r1),
        .o_data  (w_d1)
    );

    gds_stage_len u_len (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v1),
        .o_ready (w_r1),
        .i_data  (w_d1),
        .o_valid (w_v2),
        .i_ready (w_r2),
        .o_data  (w_d2)
    );

    gds_stage_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_v2),
        .o_ready (w_r2),
        .i_data  (w_d2),
        .o_valid (o_out.valid),
        .i_ready (o_out.ready),
        .o_data  (w_res)
    );

    assign o_out.date_ok      = w_res.date_ok;
    assign o_out.month_length = w_res.month_length;
    assign o_out.prev_ok      = w_res.prev_ok;
    assign o_out.prev_day     = w_res.prev.day;
    assign o_out.prev_month   = w_res.prev.month;
    assign o_out.prev_year    = w_res.prev.year;
    assign o_out.next_ok      = w_res.next_ok;
    assign o_out.next_day     = w_res.next.day;
    assign o_out.next_month   = w_res.next.month;
    assign o_out.next_year    = w_res.next.year;

endmodule
